### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers, clocked on clk with reset arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/csieof_pkg.sv
// ---------------------------------------------------------------------------
// csieof_pkg
// shared types and code-unit constants of the escape and overwrite filter
// ---------------------------------------------------------------------------
package csieof_pkg;

	localparam logic [15:0] U_ESC      = 16'h001B;
	localparam logic [15:0] U_LBRACKET = 16'h005B;
	localparam logic [15:0] U_FINAL_LO = 16'h0040;
	localparam logic [15:0] U_FINAL_HI = 16'h007E;
	localparam logic [15:0] U_CR       = 16'h000D;
	localparam logic [15:0] U_LF       = 16'h000A;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_CSI
	} mode_t;

	// what follows the stored units of a flush
	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_LF,
		TAIL_MARK
	} tail_t;

	// emission plan of one accepted word
	typedef struct packed {
		logic  flush;
		tail_t tail;
		logic  ovf;
		logic  eot;
	} plan_t;

	// one result word
	typedef struct packed {
		logic [15:0] unit;
		logic        has;
		logic        last;
		logic        done;
		logic        ovf;
	} res_t;

endpackage

### src/csi_escape_and_overwrite_filter_top.sv
// ---------------------------------------------------------------------------
// csi_escape_and_overwrite_filter_top
// strips escape sequences and overwritten lines from a 16-bit text stream
// ---------------------------------------------------------------------------
// usage
//   slave side takes one code unit per word (s_tdata), s_tlast marks end of text
//   master side gives one kept unit per word; m_tlast closes the words caused
//   by one input word, m_tuser carries has_unit, text_done, line_overflowed
//   kept units wait in a line store memory of LINE_CAPACITY entries and leave
//   when an lf arrives (lf follows them) or when the text ends
// timing
//   a word that yields nothing keeps the block idle; the next one is taken right after
//   a word that yields n results starts a flush; with a ready receiver the
//   flush reads one entry per cycle, and no input is taken until the last issue
//   first result word passes the flush state, the read stage and the output queue before it is valid
// stall
//   a two-word output queue with credit counting throttles the memory reads,
//   so a stalled receiver simply pauses the flush; nothing is lost
// reset
//   arst_n clears parse mode, pending cr, line length and overflow flag; the
//   line memory itself is not cleared (only written entries are ever read)
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csi_escape_and_overwrite_filter_top #(
	parameter int LINE_CAPACITY = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] code_unit
	input  logic        s_tlast,   // end_of_text
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] out_unit
	output logic        m_tlast,   // last_of_run
	output logic [2:0]  m_tuser    // [0] has_unit, [1] text_done, [2] line_overflowed
);

	localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
	localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} state_t;

	state_t             state_q;

	// line state
	csieof_pkg::mode_t  mode_q;
	logic               crp_q;
	logic [LEN_W-1:0]   len_q;
	logic               ovf_q;

	// flush plan captured at accept
	logic [LEN_W-1:0]   idx_q;
	logic [LEN_W-1:0]   flen_q;
	csieof_pkg::tail_t  tail_q;
	logic               fovf_q;
	logic               feot_q;

	// read stage
	logic               v_s1;
	logic               from_mem_s1;
	csieof_pkg::res_t   res_s1;

	// parse outputs
	csieof_pkg::mode_t  mode_n;
	logic               crp_n;
	logic [LEN_W-1:0]   len_n;
	logic               ovf_n;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	csieof_pkg::plan_t  plan;
	logic [LEN_W-1:0]   plan_len;

	logic               in_fire;
	logic               pop;
	logic [1:0]         buf_cnt;
	logic [2:0]         occ;
	logic               issue_ok;
	logic               issue;
	logic               is_mem;
	logic               mem_re;
	logic               issue_last;
	logic [15:0]        mem_rdata;
	csieof_pkg::res_t   push_data;
	csieof_pkg::res_t   out_res;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	csieof_parse #(
		.CAP    (LINE_CAPACITY),
		.LEN_W  (LEN_W),
		.ADDR_W (ADDR_W)
	) u_parse (
		.code_unit (s_tdata),
		.eot       (s_tlast),
		.mode_q    (mode_q),
		.crp_q     (crp_q),
		.len_q     (len_q),
		.ovf_q     (ovf_q),
		.mode_n    (mode_n),
		.crp_n     (crp_n),
		.len_n     (len_n),
		.ovf_n     (ovf_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.plan      (plan),
		.plan_len  (plan_len)
	);

	// credit: queue words plus the read in flight, minus the word leaving now
	assign occ      = 3'({1'b0, buf_cnt} + {2'b00, v_s1} - {2'b00, pop});
	assign issue_ok = (occ < 3'd2);
	assign issue    = (state_q == ST_FLUSH) && issue_ok;
	assign is_mem   = (idx_q < flen_q);
	assign mem_re   = issue && is_mem;
	// last word of the run: final stored unit with no tail, or the tail itself
	assign issue_last = is_mem ?
		((idx_q == LEN_W'(flen_q - 1'b1)) && (tail_q == csieof_pkg::TAIL_NONE)) : 1'b1;

	csieof_line_mem #(
		.DEPTH  (LINE_CAPACITY),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (in_fire && wr_en),
		.waddr (wr_addr),
		.wdata (s_tdata),
		.re    (mem_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= csieof_pkg::MODE_NORMAL;
			crp_q       <= 1'b0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			flen_q      <= '0;
			tail_q      <= csieof_pkg::TAIL_NONE;
			fovf_q      <= 1'b0;
			feot_q      <= 1'b0;
			v_s1        <= 1'b0;
			from_mem_s1 <= 1'b0;
			res_s1      <= '0;
		end else begin
			v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						mode_q <= mode_n;
						crp_q  <= crp_n;
						len_q  <= len_n;
						ovf_q  <= ovf_n;
						if (plan.flush) begin
							state_q <= ST_FLUSH;
							idx_q   <= '0;
							flen_q  <= plan_len;
							tail_q  <= plan.tail;
							fovf_q  <= plan.ovf;
							feot_q  <= plan.eot;
						end
					end
				end
				ST_FLUSH: begin
					if (issue) begin
						from_mem_s1 <= is_mem;
						res_s1.unit <= (tail_q == csieof_pkg::TAIL_LF) ?
							csieof_pkg::U_LF : 16'h0000;
						res_s1.has  <= is_mem || (tail_q == csieof_pkg::TAIL_LF);
						res_s1.last <= issue_last;
						res_s1.done <= issue_last && feot_q;
						res_s1.ovf  <= fovf_q;
						if (is_mem) begin
							idx_q <= LEN_W'(idx_q + 1'b1);
						end
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// memory data joins its word in the cycle after the read
	always_comb begin
		push_data = res_s1;
		if (from_mem_s1) begin
			push_data.unit = mem_rdata;
		end
	end

	csieof_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (push_data),
		.ready     (m_tready),
		.valid     (m_tvalid),
		.data      (out_res),
		.count     (buf_cnt)
	);

	assign m_tdata = out_res.unit;
	assign m_tlast = out_res.last;
	assign m_tuser = {out_res.ovf, out_res.done, out_res.has};

	// queue plus in-flight read never exceeds the queue depth
	`ASSERT_SAME(a_credit, 1'b1, ({1'b0, buf_cnt} + {2'b00, v_s1}) <= 3'd2, "output queue overrun")
	// a memory read always addresses a unit of the line being flushed
	`ASSERT_SAME(a_rd_in_line, mem_re, (state_q == ST_FLUSH) && (idx_q < flen_q), "read past line")
	// end of text leaves the line state at its reset values
	`ASSERT_NEXT(a_eot_clear, in_fire && s_tlast,
		(mode_q == csieof_pkg::MODE_NORMAL) && !crp_q && (len_q == '0) && !ovf_q,
		"state not cleared at end of text")
	// the final word of a run ends the flush
	`ASSERT_NEXT(a_last_ends, issue && issue_last, state_q == ST_IDLE, "flush did not end")

endmodule

### src/csieof_line_mem.sv
// ---------------------------------------------------------------------------
// csieof_line_mem
// line store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module csieof_line_mem #(
	parameter int DEPTH  = 63,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/csieof_parse.sv
// ---------------------------------------------------------------------------
// csieof_parse
// next-state and emission plan for one accepted code unit
// ---------------------------------------------------------------------------
module csieof_parse #(
	parameter int CAP    = 63,
	parameter int LEN_W  = 6,
	parameter int ADDR_W = 6
) (
	input  logic [15:0]        code_unit,
	input  logic               eot,
	input  csieof_pkg::mode_t  mode_q,
	input  logic               crp_q,
	input  logic [LEN_W-1:0]   len_q,
	input  logic               ovf_q,
	output csieof_pkg::mode_t  mode_n,
	output logic               crp_n,
	output logic [LEN_W-1:0]   len_n,
	output logic               ovf_n,
	output logic               wr_en,
	output logic [ADDR_W-1:0]  wr_addr,
	output csieof_pkg::plan_t  plan,
	output logic [LEN_W-1:0]   plan_len
);

	logic [LEN_W-1:0] len_a;
	logic             ovf_a;
	logic             lf_seen;

	always_comb begin
		mode_n   = mode_q;
		crp_n    = crp_q;
		len_a    = len_q;
		ovf_a    = ovf_q;
		wr_en    = 1'b0;
		wr_addr  = len_q[ADDR_W-1:0];
		plan     = '0;
		plan_len = '0;
		lf_seen  = 1'b0;

		unique case (mode_q)
			csieof_pkg::MODE_ESC: begin
				mode_n = (code_unit == csieof_pkg::U_LBRACKET) ?
					csieof_pkg::MODE_CSI : csieof_pkg::MODE_NORMAL;
			end
			csieof_pkg::MODE_CSI: begin
				if (code_unit >= csieof_pkg::U_FINAL_LO &&
						code_unit <= csieof_pkg::U_FINAL_HI) begin
					mode_n = csieof_pkg::MODE_NORMAL;
				end
			end
			default: begin
				// bare cr erases the line unless lf follows
				if (crp_q) begin
					crp_n = 1'b0;
					if (code_unit != csieof_pkg::U_LF) begin
						len_a = '0;
						ovf_a = 1'b0;
					end
				end
				priority if (code_unit == csieof_pkg::U_ESC) begin
					mode_n = csieof_pkg::MODE_ESC;
				end else if (code_unit == csieof_pkg::U_CR) begin
					crp_n = 1'b1;
				end else if (code_unit == csieof_pkg::U_LF) begin
					plan.flush = 1'b1;
					plan.tail  = csieof_pkg::TAIL_LF;
					plan.ovf   = ovf_a;
					plan_len   = len_a;
					len_a      = '0;
					ovf_a      = 1'b0;
					lf_seen    = 1'b1;
				end else if (len_a < LEN_W'(CAP)) begin
					wr_en   = 1'b1;
					wr_addr = len_a[ADDR_W-1:0];
					len_a   = LEN_W'(len_a + 1'b1);
				end else begin
					ovf_a = 1'b1;
				end
			end
		endcase

		if (eot) begin
			if (!lf_seen) begin
				if (crp_n) begin
					len_a = '0;
					ovf_a = 1'b0;
				end
				plan.flush = 1'b1;
				plan.ovf   = ovf_a;
				plan_len   = len_a;
				plan.tail  = (len_a == '0) ? csieof_pkg::TAIL_MARK : csieof_pkg::TAIL_NONE;
			end
			plan.eot = 1'b1;
			mode_n   = csieof_pkg::MODE_NORMAL;
			crp_n    = 1'b0;
			len_a    = '0;
			ovf_a    = 1'b0;
		end

		len_n = len_a;
		ovf_n = ovf_a;
	end

endmodule

### src/csieof_out_buf.sv
// ---------------------------------------------------------------------------
// csieof_out_buf
// two-word output queue between the flush pipeline and the master port
// ---------------------------------------------------------------------------
module csieof_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csieof_pkg::res_t   push_data,
	input  logic               ready,
	output logic               valid,
	output csieof_pkg::res_t   data,
	output logic [1:0]         count
);

	csieof_pkg::res_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign valid = (cnt_q != 2'd0);
	assign data  = entry_q[rd_ptr_q];
	assign count = cnt_q;
	assign pop   = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// payload storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
